>>> src/esc_pkg.sv
// Package for the eased solo crossfader: widths, codes, shared structs and the
// in-out-exponential easing table, which is built at elaboration.
// Depends on nothing; every other file imports it.
`default_nettype none

package esc_pkg;

	localparam int SAMPLE_BITS     = 24;
	localparam int EASE_TABLE_BITS = 10;

	localparam int LEVEL_W     = 25;
	localparam int GAIN_STEP_W = 25;
	localparam int SOLO_GAIN_W = 16;
	localparam int CFG_DATA_W  = 25;
	localparam int CFG_INDEX_W = 1;

	localparam int SOLO_FRAC = 14;
	localparam int GAIN_FRAC = 24;

	localparam int SCALED_W = SAMPLE_BITS + 2;
	localparam int DIFF_W   = SAMPLE_BITS + 3;
	localparam int MUL_Y_W  = LEVEL_W + 1;
	localparam int PROD_W   = DIFF_W + MUL_Y_W;
	localparam int RES_W    = DIFF_W + 1;

	localparam int TBL_SIZE       = 1 << EASE_TABLE_BITS;
	localparam int EASE_W         = 24;
	localparam int EASE_BANK_BITS = (EASE_TABLE_BITS > 8) ? (EASE_TABLE_BITS - 8) : 1;
	localparam int EASE_IDX_BITS  = EASE_TABLE_BITS - EASE_BANK_BITS;
	localparam int EASE_BANKS     = 1 << EASE_BANK_BITS;

	localparam logic [LEVEL_W-1:0] UNITY = {1'b1, {(LEVEL_W-1){1'b0}}};

	typedef logic [1:0] command_t;
	localparam command_t CMD_SAMPLE    = 2'd0;
	localparam command_t CMD_START     = 2'd1;
	localparam command_t CMD_STOP      = 2'd2;
	localparam command_t CMD_BLOCK_END = 2'd3;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_INACTIVE = 2'd0;
	localparam mode_t MODE_TRANS    = 2'd1;
	localparam mode_t MODE_ACTIVE   = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_GAIN_STEP = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SOLO_GAIN = 1'd1;

	localparam logic [GAIN_STEP_W-1:0] GAIN_STEP_RESET = 25'd2796;
	localparam logic [SOLO_GAIN_W-1:0] SOLO_GAIN_RESET = 16'd4096;

	typedef struct packed {
		logic capture;
		logic exec;
		logic scale_a;
		logic diff;
		logic lerp;
		logic load_out;
	} esc_cmd_t;

	typedef struct packed {
		logic               is_sample;
		logic               prim_on;
		logic               both;
		logic [LEVEL_W-1:0] prim_level;
		logic               done;
		logic               ignored;
	} esc_slot_stat_t;

	typedef logic [63:0] root_arr_t [EASE_TABLE_BITS+1];
	typedef logic [EASE_W-1:0] ease_rom_t [TBL_SIZE];

	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bits;
		v    = n;
		res  = 64'd0;
		bits = 64'd1 << 62;
		while (bits > v) bits = bits >> 2;
		while (bits != 64'd0) begin
			if (v >= res + bits) begin
				v   = v - res - bits;
				res = (res >> 1) + bits;
			end else begin
				res = res >> 1;
			end
			bits = bits >> 2;
		end
		return res;
	endfunction

	function automatic root_arr_t build_roots();
		root_arr_t r;
		r[0] = 64'd2 << 30;
		for (int k = 1; k <= EASE_TABLE_BITS; k++) begin
			r[k] = isqrt64(r[k-1] << 30);
		end
		return r;
	endfunction

	localparam root_arr_t ROOT_C = build_roots();

	function automatic logic [63:0] pow2_frac(input logic [63:0] r);
		logic [63:0] acc;
		acc = 64'd1 << 30;
		for (int k = 1; k <= EASE_TABLE_BITS; k++) begin
			if (((r >> (EASE_TABLE_BITS - k)) & 64'd1) != 64'd0) begin
				acc = (acc * ROOT_C[k] + (64'd1 << 29)) >> 30;
			end
		end
		return acc;
	endfunction

	function automatic ease_rom_t build_ease_rom();
		ease_rom_t   tbl;
		logic [63:0] s;
		logic [63:0] t;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] e;
		logic [63:0] acc;
		logic [63:0] sh;
		logic [63:0] mask;
		logic [63:0] val;
		mask = 64'(TBL_SIZE) - 64'd1;
		for (int i = 0; i < TBL_SIZE; i++) begin
			s = 64'd20 * 64'(i);
			if (i < (TBL_SIZE >> 1)) begin
				q   = s >> EASE_TABLE_BITS;
				sh  = 64'd17 - q;
				acc = pow2_frac(s & mask);
				val = (acc + (64'd1 << (sh - 64'd1))) >> sh;
			end else begin
				t   = s - 64'd9 * 64'(TBL_SIZE);
				q   = t >> EASE_TABLE_BITS;
				r   = t & mask;
				e   = q;
				acc = 64'd1 << 30;
				if (r != 64'd0) begin
					acc = pow2_frac(64'(TBL_SIZE) - r);
					e   = q + 64'd1;
				end
				sh  = 64'd6 + e;
				val = (64'd1 << 24) - ((acc + (64'd1 << (sh - 64'd1))) >> sh);
			end
			tbl[i] = val[EASE_W-1:0];
		end
		tbl[0] = '0;
		return tbl;
	endfunction

	localparam ease_rom_t EASE_ROM = build_ease_rom();

endpackage

`default_nettype wire

>>> src/esc_ctrl.sv
// Controller of the eased solo crossfader: sequences one item through the
// shared multiplier and owns both channel handshakes. Depends on esc_pkg.
`default_nettype none

module esc_ctrl import esc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     item_valid,
	output logic          item_stall,
	input  wire command_t command,
	output logic          result_valid,
	input  wire logic     result_stall,
	output esc_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_EXEC    = 3'd1;
	localparam logic [2:0] S_SCALE_A = 3'd2;
	localparam logic [2:0] S_DIFF    = 3'd3;
	localparam logic [2:0] S_LERP    = 3'd4;
	localparam logic [2:0] S_FINISH  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       sample_q;
	logic       out_valid_q;
	logic       accept;
	logic       load_out;

	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && (state_q == S_IDLE);
	assign load_out     = (state_q == S_FINISH) && (!out_valid_q || !result_stall);
	assign result_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (item_valid) state_d = S_EXEC;
			S_EXEC:    state_d = sample_q ? S_SCALE_A : S_FINISH;
			S_SCALE_A: state_d = S_DIFF;
			S_DIFF:    state_d = S_LERP;
			S_LERP:    state_d = S_FINISH;
			S_FINISH:  if (load_out) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sample_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) sample_q <= (command == CMD_SAMPLE);
			if (load_out) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.capture  = accept;
		cmd.exec     = (state_q == S_EXEC);
		cmd.scale_a  = (state_q == S_SCALE_A);
		cmd.diff     = (state_q == S_DIFF);
		cmd.lerp     = (state_q == S_LERP);
		cmd.load_out = load_out;
	end

endmodule

`default_nettype wire

>>> src/esc_slots.sv
// Fade slot state of the eased solo crossfader: gain stepping, start, stop and
// block-end settling, plus the gain step register. Depends on esc_pkg.
`default_nettype none

module esc_slots import esc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire command_t               command,
	input  wire logic                   new_frame,
	input  wire esc_cmd_t               cmd,
	output esc_slot_stat_t              stat
);

	logic [GAIN_STEP_W-1:0] gain_step_q;
	command_t               cmd_q;
	logic                   nf_q;

	mode_t              p_mode_q, p_mode_d;
	logic [LEVEL_W-1:0] p_level_q, p_level_d;
	logic               p_rise_q, p_rise_d;
	mode_t              a_mode_q, a_mode_d;
	logic [LEVEL_W-1:0] a_level_q, a_level_d;
	logic               a_rise_q, a_rise_d;
	logic               in_trans_q, in_trans_d;
	logic               done_q, done_d;
	logic               ignored_q, ignored_d;
	logic               p_fin;
	logic               a_fin;

	function automatic logic [LEVEL_W-1:0] step_level(
		input logic [LEVEL_W-1:0]     lvl,
		input logic                   rise,
		input logic [GAIN_STEP_W-1:0] stp
	);
		logic [LEVEL_W:0] sum;
		sum = {1'b0, lvl} + {1'b0, stp};
		if (rise) begin
			return (sum > {1'b0, UNITY}) ? UNITY : sum[LEVEL_W-1:0];
		end
		return (lvl > stp) ? (lvl - stp) : '0;
	endfunction

	always_comb begin
		p_mode_d   = p_mode_q;
		p_level_d  = p_level_q;
		p_rise_d   = p_rise_q;
		a_mode_d   = a_mode_q;
		a_level_d  = a_level_q;
		a_rise_d   = a_rise_q;
		in_trans_d = in_trans_q;
		done_d     = 1'b0;
		ignored_d  = 1'b0;
		p_fin      = 1'b1;
		a_fin      = 1'b1;
		case (cmd_q)
			CMD_SAMPLE: begin
				if (nf_q && (p_mode_q != MODE_INACTIVE)) begin
					p_level_d = step_level(p_level_q, p_rise_q, gain_step_q);
					if (a_mode_q != MODE_INACTIVE) begin
						a_level_d = step_level(a_level_q, a_rise_q, gain_step_q);
					end
				end
			end
			CMD_START, CMD_STOP: begin
				if (in_trans_q) begin
					ignored_d = 1'b1;
				end else begin
					if (cmd_q == CMD_STOP) begin
						p_rise_d = 1'b0;
					end else begin
						if (p_mode_q == MODE_ACTIVE) begin
							a_mode_d  = MODE_TRANS;
							a_level_d = p_level_q;
							a_rise_d  = 1'b0;
						end
						p_level_d = '0;
						p_rise_d  = 1'b1;
					end
					p_mode_d   = MODE_TRANS;
					in_trans_d = 1'b1;
				end
			end
			CMD_BLOCK_END: begin
				if (in_trans_q) begin
					if (p_mode_q == MODE_TRANS) begin
						p_fin = (p_level_q == (p_rise_q ? UNITY : '0));
						if (p_fin) begin
							if (p_rise_q) begin
								p_mode_d = MODE_ACTIVE;
							end else begin
								p_mode_d  = MODE_INACTIVE;
								p_level_d = '0;
								p_rise_d  = 1'b0;
							end
						end
					end
					if (a_mode_q == MODE_TRANS) begin
						a_fin = (a_level_q == (a_rise_q ? UNITY : '0));
						if (a_fin) begin
							if (a_rise_q) begin
								a_mode_d = MODE_ACTIVE;
							end else begin
								a_mode_d  = MODE_INACTIVE;
								a_level_d = '0;
								a_rise_d  = 1'b0;
							end
						end
					end
					if (p_fin && a_fin) begin
						in_trans_d = 1'b0;
						done_d     = 1'b1;
					end
				end
			end
			default: begin
				ignored_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= command;
			nf_q  <= new_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_step_q <= GAIN_STEP_RESET;
			p_mode_q    <= MODE_INACTIVE;
			p_level_q   <= '0;
			p_rise_q    <= 1'b0;
			a_mode_q    <= MODE_INACTIVE;
			a_level_q   <= '0;
			a_rise_q    <= 1'b0;
			in_trans_q  <= 1'b0;
			done_q      <= 1'b0;
			ignored_q   <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == REG_GAIN_STEP)) begin
				gain_step_q <= cfg_data[GAIN_STEP_W-1:0];
			end
			if (cmd.exec) begin
				p_mode_q   <= p_mode_d;
				p_level_q  <= p_level_d;
				p_rise_q   <= p_rise_d;
				a_mode_q   <= a_mode_d;
				a_level_q  <= a_level_d;
				a_rise_q   <= a_rise_d;
				in_trans_q <= in_trans_d;
				done_q     <= done_d;
				ignored_q  <= ignored_d;
			end
		end
	end

	always_comb begin
		stat            = '0;
		stat.is_sample  = (cmd_q == CMD_SAMPLE);
		stat.prim_on    = (p_mode_q != MODE_INACTIVE);
		stat.both       = (a_mode_q != MODE_INACTIVE);
		stat.prim_level = p_level_q;
		stat.done       = done_q;
		stat.ignored    = ignored_q;
	end

endmodule

`default_nettype wire

>>> src/esc_datapath.sv
// Datapath of the eased solo crossfader: sample capture, solo scaling, eased
// gain lookup, the shared multiplier and the result register. Depends on esc_pkg.
`default_nettype none

module esc_datapath import esc_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data,
	input  wire logic signed [SAMPLE_BITS-1:0] mix_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] primary_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] auxiliary_sample,
	input  wire esc_cmd_t                      cmd,
	input  wire esc_slot_stat_t                stat,
	output logic signed [SAMPLE_BITS-1:0]      out_sample,
	output logic                               fade_done,
	output logic                               command_ignored
);

	localparam logic signed [RES_W-1:0] SAT_HI =
		RES_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RES_W-1:0] SAT_LO =
		RES_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
	localparam logic [PROD_W-1:0] SCALE_HALF = PROD_W'(1) << (SOLO_FRAC - 1);
	localparam logic [PROD_W-1:0] GAIN_HALF  = PROD_W'(1) << (GAIN_FRAC - 1);

	logic [SOLO_GAIN_W-1:0]        solo_gain_q;
	logic signed [SAMPLE_BITS-1:0] mix_q;
	logic signed [SAMPLE_BITS-1:0] prim_q;
	logic signed [SAMPLE_BITS-1:0] aux_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [SCALED_W-1:0]    b_q;
	logic signed [SCALED_W-1:0]    a_q;
	logic signed [DIFF_W-1:0]      diff_q;
	logic [LEVEL_W-1:0]            g_q;
	logic [EASE_W-1:0]             ease_bank_q [EASE_BANKS];
	logic                          ease_unity_q;

	logic signed [SAMPLE_BITS-1:0] out_sample_q;
	logic                          fade_done_q;
	logic                          command_ignored_q;

	logic signed [DIFF_W-1:0]      mul_x;
	logic signed [MUL_Y_W-1:0]     mul_y;
	logic signed [PROD_W-1:0]      mul_x_ext;
	logic signed [PROD_W-1:0]      mul_y_ext;
	logic signed [PROD_W-1:0]      mul_p;
	logic [PROD_W-1:0]             scaled_sum;
	logic signed [SCALED_W-1:0]    scaled;
	logic signed [SCALED_W-1:0]    a_sel;
	logic [EASE_IDX_BITS-1:0]      ease_idx;
	logic [EASE_BANK_BITS-1:0]     ease_bank;
	logic [PROD_W-1:0]             lerp_sum;
	logic signed [DIFF_W-1:0]      lerp_term;
	logic signed [RES_W-1:0]       res_sum;
	logic signed [SAMPLE_BITS-1:0] res_sat;

	always_comb begin
		mul_x = diff_q;
		mul_y = {1'b0, g_q};
		if (cmd.exec) begin
			mul_x = DIFF_W'(prim_q);
			mul_y = {{(MUL_Y_W-SOLO_GAIN_W){1'b0}}, solo_gain_q};
		end else if (cmd.scale_a) begin
			mul_x = DIFF_W'(aux_q);
			mul_y = {{(MUL_Y_W-SOLO_GAIN_W){1'b0}}, solo_gain_q};
		end
	end

	assign mul_x_ext = {{(PROD_W-DIFF_W){mul_x[DIFF_W-1]}}, mul_x};
	assign mul_y_ext = {{(PROD_W-MUL_Y_W){mul_y[MUL_Y_W-1]}}, mul_y};
	assign mul_p     = mul_x_ext * mul_y_ext;

	assign scaled_sum = prod_q + SCALE_HALF;
	assign scaled     = scaled_sum[SOLO_FRAC +: SCALED_W];
	assign a_sel      = stat.both ? scaled : SCALED_W'(mix_q);

	assign ease_bank = stat.prim_level[GAIN_FRAC-1 -: EASE_BANK_BITS];
	assign ease_idx  = stat.prim_level[GAIN_FRAC-1-EASE_BANK_BITS -: EASE_IDX_BITS];

	assign lerp_sum  = prod_q + GAIN_HALF;
	assign lerp_term = lerp_sum[GAIN_FRAC +: DIFF_W];
	assign res_sum   = RES_W'(a_q) + RES_W'(lerp_term);

	always_comb begin
		if (res_sum > SAT_HI) begin
			res_sat = SAT_HI[SAMPLE_BITS-1:0];
		end else if (res_sum < SAT_LO) begin
			res_sat = SAT_LO[SAMPLE_BITS-1:0];
		end else begin
			res_sat = res_sum[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solo_gain_q <= SOLO_GAIN_RESET;
		end else if (cfg_we && (cfg_index == REG_SOLO_GAIN)) begin
			solo_gain_q <= cfg_data[SOLO_GAIN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mix_q  <= mix_sample;
			prim_q <= primary_sample;
			aux_q  <= auxiliary_sample;
		end
		if (cmd.exec || cmd.scale_a || cmd.lerp) begin
			prod_q <= mul_p;
		end
		if (cmd.scale_a) begin
			b_q          <= scaled;
			ease_unity_q <= stat.prim_level[LEVEL_W-1];
			for (int j = 0; j < EASE_BANKS; j++) begin
				ease_bank_q[j] <= EASE_ROM[{EASE_BANK_BITS'(j), ease_idx}];
			end
		end
		if (cmd.diff) begin
			a_q    <= a_sel;
			diff_q <= DIFF_W'(b_q) - DIFF_W'(a_sel);
			g_q    <= ease_unity_q ? UNITY : {1'b0, ease_bank_q[ease_bank]};
		end
		if (cmd.load_out) begin
			if (!stat.is_sample) begin
				out_sample_q <= '0;
			end else if (stat.prim_on) begin
				out_sample_q <= res_sat;
			end else begin
				out_sample_q <= mix_q;
			end
			fade_done_q       <= stat.done;
			command_ignored_q <= stat.ignored;
		end
	end

	assign out_sample      = out_sample_q;
	assign fade_done       = fade_done_q;
	assign command_ignored = command_ignored_q;

endmodule

`default_nettype wire

>>> src/eased_solo_crossfader.sv
// Top level of the eased solo crossfader: joins controller, fade slots and
// datapath. Depends on esc_pkg, esc_ctrl, esc_slots and esc_datapath.
//
//   channel   handshake                   beat contents
//   item      item_valid / item_stall     command, new_frame, mix/primary/auxiliary_sample
//   result    result_valid / result_stall out_sample, fade_done, command_ignored
//   config    cfg_we                      cfg_index, cfg_data
//
// A sample beat steps through the exec, scale, diff, lerp and finish states, a command
// beat through exec and finish only. The sample steps are set by the single shared
// multiplier, used in turn for primary scale, auxiliary scale and gain interpolation.
// Reset is asynchronous and clears all fade state at once, with no clearing pass.
// A finished result waits in the output register, so a stalled result only holds
// the block once the next beat is also complete.
`default_nettype none

module eased_solo_crossfader import esc_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire logic [1:0]                    command,
	input  wire logic                          new_frame,
	input  wire logic signed [SAMPLE_BITS-1:0] mix_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] primary_sample,
	input  wire logic signed [SAMPLE_BITS-1:0] auxiliary_sample,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic signed [SAMPLE_BITS-1:0]      out_sample,
	output logic                               fade_done,
	output logic                               command_ignored
);

	esc_cmd_t       cmd;
	esc_slot_stat_t stat;

	esc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.command      (command),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	esc_slots u_slots (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.command   (command),
		.new_frame (new_frame),
		.cmd       (cmd),
		.stat      (stat)
	);

	esc_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mix_sample       (mix_sample),
		.primary_sample   (primary_sample),
		.auxiliary_sample (auxiliary_sample),
		.cmd              (cmd),
		.stat             (stat),
		.out_sample       (out_sample),
		.fade_done        (fade_done),
		.command_ignored  (command_ignored)
	);

endmodule

`default_nettype wire

>>> src/esc_checker.sv
// Port-level checks for the eased solo crossfader, bound to the top level.
// Depends on esc_pkg and watches only the ports of eased_solo_crossfader.
`default_nettype none

module esc_checker import esc_pkg::*; (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          item_valid,
	input wire logic                          item_stall,
	input wire logic                          result_valid,
	input wire logic                          result_stall,
	input wire logic signed [SAMPLE_BITS-1:0] out_sample,
	input wire logic                          fade_done,
	input wire logic                          command_ignored
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("item accepted without the block going busy");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(fade_done && command_ignored))
		else $error("done and ignored flags on the same beat");

	a_command_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (fade_done || command_ignored)) |-> (out_sample == '0))
		else $error("command beat carries a nonzero sample");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
			(result_valid && $stable(out_sample) && $stable(fade_done)
			&& $stable(command_ignored)))
		else $error("stalled result changed");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result appeared while the block was idle");

endmodule

bind eased_solo_crossfader esc_checker u_esc_checker (.*);

`default_nettype wire

>>> sim/crossfade_checker.sv
`timescale 1ns / 1ps
// Checker for the eased solo crossfader: watches the register port and both channels,
// predicts every result beat from its own copy of the fade state and compares it.
// Depends on esc_pkg for widths, codes and register indexes.

module crossfade_checker import esc_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          item_valid,
	input  logic                          item_stall,
	input  logic [1:0]                    command,
	input  logic                          new_frame,
	input  logic signed [SAMPLE_BITS-1:0] mix_sample,
	input  logic signed [SAMPLE_BITS-1:0] primary_sample,
	input  logic signed [SAMPLE_BITS-1:0] auxiliary_sample,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic signed [SAMPLE_BITS-1:0] out_sample,
	input  logic                          fade_done,
	input  logic                          command_ignored,
	output int                            mismatches,
	output int                            outstanding,
	output int                            done_pulses,
	output int                            refusals
);

	typedef struct packed {
		mode_t              mode;
		logic [LEVEL_W-1:0] level;
		logic               rising;
	} fade_slot_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          done;
		logic                          ignored;
	} crossfade_out_t;

	localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	longint unsigned        ease_curve [TBL_SIZE];
	longint unsigned        unit_roots [EASE_TABLE_BITS+1];
	fade_slot_t             primary_slot;
	fade_slot_t             auxiliary_slot;
	logic                   fading;
	logic [GAIN_STEP_W-1:0] step_size;
	logic [SOLO_GAIN_W-1:0] capture_gain;
	crossfade_out_t         pending_outputs [$];

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned probe;
		rem   = n;
		root  = 0;
		probe = 64'd1 << 62;
		while (probe > rem) probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem  = rem - root - probe;
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic longint unsigned exp2_q30(input int unsigned frac);
		longint unsigned acc;
		acc = 64'd1 << 30;
		for (int k = 1; k <= EASE_TABLE_BITS; k++) begin
			if (((frac >> (EASE_TABLE_BITS - k)) & 1) != 0) begin
				acc = (acc * unit_roots[k] + (64'd1 << 29)) >> 30;
			end
		end
		return acc;
	endfunction

	initial begin : build_curve
		int unsigned     s;
		int unsigned     q;
		int unsigned     r;
		int unsigned     sh;
		longint unsigned acc;
		unit_roots[0] = 64'd2 << 30;
		for (int k = 1; k <= EASE_TABLE_BITS; k++) begin
			unit_roots[k] = floor_sqrt(unit_roots[k-1] << 30);
		end
		for (int i = 0; i < TBL_SIZE; i++) begin
			s = 20 * i;
			if (i < TBL_SIZE / 2) begin
				sh  = 17 - (s >> EASE_TABLE_BITS);
				acc = exp2_q30(s % TBL_SIZE);
			end else begin
				q   = (s - 9 * TBL_SIZE) >> EASE_TABLE_BITS;
				r   = (s - 9 * TBL_SIZE) % TBL_SIZE;
				acc = 64'd1 << 30;
				sh  = 6 + q;
				if (r != 0) begin
					acc = exp2_q30(TBL_SIZE - r);
					sh  = 7 + q;
				end
			end
			acc = (acc + (64'd1 << (sh - 1))) >> sh;
			ease_curve[i] = (i < TBL_SIZE / 2) ? acc : (64'd1 << 24) - acc;
		end
		ease_curve[0] = 0;
	end

	function automatic longint round_off(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint scale_capture(input longint x);
		return round_off(x * longint'(capture_gain), SOLO_FRAC);
	endfunction

	task automatic advance_level(inout fade_slot_t sl);
		longint lv;
		lv = longint'(sl.level);
		if (sl.rising) begin
			lv = lv + longint'(step_size);
			if (lv > longint'(UNITY)) lv = longint'(UNITY);
		end else begin
			lv = (lv > longint'(step_size)) ? lv - longint'(step_size) : 0;
		end
		sl.level = lv[LEVEL_W-1:0];
	endtask

	task automatic settle_slot(inout fade_slot_t sl, output logic reached);
		logic [LEVEL_W-1:0] goal;
		goal    = sl.rising ? UNITY : '0;
		reached = (sl.level == goal);
		if (reached) begin
			if (sl.rising) begin
				sl.mode = MODE_ACTIVE;
			end else begin
				sl.mode   = MODE_INACTIVE;
				sl.level  = '0;
				sl.rising = 1'b0;
			end
		end
	endtask

	task automatic predict_output(output crossfade_out_t res);
		longint mix;
		longint a;
		longint b;
		longint g;
		longint y;
		logic   both;
		logic   prim_ok;
		logic   aux_ok;
		res = '0;
		case (command)
		CMD_SAMPLE: begin
			mix = longint'(mix_sample);
			y   = mix;
			if (primary_slot.mode != MODE_INACTIVE) begin
				both = (auxiliary_slot.mode != MODE_INACTIVE);
				if (new_frame) begin
					advance_level(primary_slot);
					if (both) advance_level(auxiliary_slot);
				end
				if (primary_slot.level >= UNITY) begin
					g = longint'(UNITY);
				end else begin
					g = ease_curve[primary_slot.level[GAIN_FRAC-1:GAIN_FRAC-EASE_TABLE_BITS]];
				end
				b = scale_capture(longint'(primary_sample));
				a = both ? scale_capture(longint'(auxiliary_sample)) : mix;
				y = a + round_off(g * (b - a), GAIN_FRAC);
			end
			if (y > SAT_HI) y = SAT_HI;
			if (y < SAT_LO) y = SAT_LO;
			res.sample = y[SAMPLE_BITS-1:0];
		end
		CMD_START, CMD_STOP: begin
			if (fading) begin
				res.ignored = 1'b1;
			end else begin
				if (command == CMD_STOP) begin
					primary_slot.rising = 1'b0;
				end else begin
					if (primary_slot.mode == MODE_ACTIVE) begin
						auxiliary_slot        = primary_slot;
						auxiliary_slot.rising = 1'b0;
						auxiliary_slot.mode   = MODE_TRANS;
					end
					primary_slot.level  = '0;
					primary_slot.rising = 1'b1;
				end
				primary_slot.mode = MODE_TRANS;
				fading            = 1'b1;
			end
		end
		default: begin
			if (fading) begin
				prim_ok = 1'b1;
				aux_ok  = 1'b1;
				if (primary_slot.mode == MODE_TRANS) settle_slot(primary_slot, prim_ok);
				if (auxiliary_slot.mode == MODE_TRANS) settle_slot(auxiliary_slot, aux_ok);
				if (prim_ok && aux_ok) begin
					fading   = 1'b0;
					res.done = 1'b1;
				end
			end
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		crossfade_out_t fresh;
		crossfade_out_t got;
		crossfade_out_t want;
		if (!arst_n) begin
			primary_slot   = '0;
			auxiliary_slot = '0;
			fading         = 1'b0;
			step_size      = GAIN_STEP_RESET;
			capture_gain   = SOLO_GAIN_RESET;
			pending_outputs.delete();
			mismatches  = 0;
			outstanding = 0;
			done_pulses = 0;
			refusals    = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_GAIN_STEP) step_size = cfg_data[GAIN_STEP_W-1:0];
				else if (cfg_index == REG_SOLO_GAIN) capture_gain = cfg_data[SOLO_GAIN_W-1:0];
			end
			if (item_valid && !item_stall) begin
				predict_output(fresh);
				pending_outputs.push_back(fresh);
			end
			if (result_valid && !result_stall) begin
				got.sample  = out_sample;
				got.done    = fade_done;
				got.ignored = command_ignored;
				if (got.done === 1'b1) done_pulses++;
				if (got.ignored === 1'b1) refusals++;
				if (pending_outputs.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result beat: sample %0d done %0b ignored %0b",
							got.sample, got.done, got.ignored);
				end else begin
					want = pending_outputs.pop_front();
					if (got.sample !== want.sample || got.done !== want.done ||
							got.ignored !== want.ignored) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected sample %0d done %0b ignored %0b, got sample %0d done %0b ignored %0b",
								want.sample, want.done, want.ignored,
								got.sample, got.done, got.ignored);
					end
				end
			end
			outstanding = pending_outputs.size();
		end
	end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Top of the crossfader testbench: clock, reset, register writes, item beats and
// result back-pressure, then the verdict. Depends on esc_pkg, eased_solo_crossfader
// and crossfade_checker.

module testbench;
	import esc_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_ZERO = '0;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic [CFG_INDEX_W-1:0]        cfg_index;
	logic [CFG_DATA_W-1:0]         cfg_data;
	logic                          item_valid;
	logic                          item_stall;
	logic [1:0]                    command;
	logic                          new_frame;
	logic signed [SAMPLE_BITS-1:0] mix_sample;
	logic signed [SAMPLE_BITS-1:0] primary_sample;
	logic signed [SAMPLE_BITS-1:0] auxiliary_sample;
	logic                          result_valid;
	logic                          result_stall;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic                          fade_done;
	logic                          command_ignored;
	int                            mismatches;
	int                            outstanding;
	int                            done_pulses;
	int                            refusals;
	int                            cycles = 0;
	int                            idle_pct = 10;
	int                            beats_sent = 0;
	int                            settings_used = 0;
	logic                          hold_off_req = 1'b0;

	eased_solo_crossfader dut (.*);
	crossfade_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : receiver
		logic held;
		held = 1'b0;
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !held) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(19))
		0: return S_MAX;
		1: return S_MIN;
		2: return S_ZERO;
		default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	task automatic send_beat(input command_t cmd, input logic nf,
			input logic signed [SAMPLE_BITS-1:0] mix, prim, aux);
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid       <= 1'b1;
		command          <= cmd;
		new_frame        <= nf;
		mix_sample       <= mix;
		primary_sample   <= prim;
		auxiliary_sample <= aux;
		do @(posedge clk); while (item_stall);
		beats_sent++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic retune(input logic [GAIN_STEP_W-1:0] step,
			input logic [SOLO_GAIN_W-1:0] gain);
		drain();
		write_reg(REG_GAIN_STEP, CFG_DATA_W'(step));
		write_reg(REG_SOLO_GAIN, CFG_DATA_W'(gain));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic random_phase(input int count);
		int pick;
		int nchan;
		int channel;
		nchan   = $urandom_range(2, 1);
		channel = 0;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_beat(CMD_SAMPLE, channel == 0, pick_sample(), pick_sample(), pick_sample());
				channel = (channel + 1) % nchan;
			end else if (pick < 80) begin
				send_beat(CMD_BLOCK_END, 1'($urandom_range(1)), pick_sample(), pick_sample(),
					pick_sample());
			end else if (pick < 87) begin
				send_beat(CMD_START, 1'($urandom_range(1)), pick_sample(), pick_sample(),
					pick_sample());
			end else if (pick < 94) begin
				send_beat(CMD_STOP, 1'($urandom_range(1)), pick_sample(), pick_sample(),
					pick_sample());
			end else begin
				send_beat(CMD_SAMPLE, 1'($urandom_range(1)), pick_sample(), pick_sample(),
					pick_sample());
			end
		end
	endtask

	initial begin : stimulus
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= '0;
		cfg_data         <= '0;
		item_valid       <= 1'b0;
		command          <= CMD_SAMPLE;
		new_frame        <= 1'b0;
		mix_sample       <= '0;
		primary_sample   <= '0;
		auxiliary_sample <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: pass-through, refused commands and a stop from an idle primary.
		send_beat(CMD_SAMPLE, 1'b1, S_MAX, S_MIN, S_MIN);
		send_beat(CMD_SAMPLE, 1'b0, S_MIN, S_MAX, S_MAX);
		send_beat(CMD_BLOCK_END, 1'b0, S_ZERO, S_ZERO, S_ZERO);
		send_beat(CMD_STOP, 1'b0, S_ZERO, S_ZERO, S_ZERO);
		send_beat(CMD_START, 1'b1, S_ZERO, S_ZERO, S_ZERO);
		send_beat(CMD_STOP, 1'b1, S_ZERO, S_ZERO, S_ZERO);
		send_beat(CMD_SAMPLE, 1'b1, 24'sh123456, S_MAX, S_MIN);
		send_beat(CMD_BLOCK_END, 1'b1, S_MAX, S_MAX, S_MAX);

		// Full-scale step and largest capture gain: one-frame fades and saturation.
		retune(UNITY, 16'hFFFF);
		send_beat(CMD_START, 1'b0, S_ZERO, S_ZERO, S_ZERO);
		send_beat(CMD_SAMPLE, 1'b1, S_MIN, S_MAX, S_MIN);
		send_beat(CMD_SAMPLE, 1'b0, S_MAX, S_MIN, S_MAX);
		send_beat(CMD_BLOCK_END, 1'b0, S_ZERO, S_ZERO, S_ZERO);
		send_beat(CMD_START, 1'b0, S_ZERO, S_ZERO, S_ZERO);
		send_beat(CMD_SAMPLE, 1'b0, S_ZERO, S_ZERO, S_MAX);
		send_beat(CMD_SAMPLE, 1'b1, -24'sd1, S_MIN, S_MAX);
		send_beat(CMD_BLOCK_END, 1'b0, S_ZERO, S_ZERO, S_ZERO);
		send_beat(CMD_STOP, 1'b0, S_ZERO, S_ZERO, S_ZERO);
		send_beat(CMD_SAMPLE, 1'b1, S_MAX, S_MAX, S_MAX);
		send_beat(CMD_BLOCK_END, 1'b0, S_ZERO, S_ZERO, S_ZERO);

		// A zero step never finishes a fade.
		retune('0, '0);
		send_beat(CMD_START, 1'b0, S_ZERO, S_ZERO, S_ZERO);
		send_beat(CMD_SAMPLE, 1'b1, S_MAX, S_MIN, S_MAX);
		send_beat(CMD_BLOCK_END, 1'b0, S_ZERO, S_ZERO, S_ZERO);

		retune(25'd1 << 23, 16'd16384);
		send_beat(CMD_SAMPLE, 1'b1, 24'sh400000, -24'sh400000, S_ZERO);
		send_beat(CMD_SAMPLE, 1'b1, S_MIN, S_MAX, S_ZERO);
		send_beat(CMD_BLOCK_END, 1'b0, S_ZERO, S_ZERO, S_ZERO);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
			0: retune(25'd1 << 21, 16'd4096);
			1: retune(UNITY, 16'hFFFF);
			2: retune(25'd1, 16'd0);
			default: retune(GAIN_STEP_W'($urandom_range(1 << 24, 1 << 16)),
				SOLO_GAIN_W'($urandom_range(65535)));
			endcase
			idle_pct     = (ph == 1) ? 0 : 10;
			hold_off_req = (ph == 3);
			random_phase((ph == 2) ? 100 : 280);
		end

		drain();
		repeat (50) @(posedge clk);
		$display("Sent %0d beats under %0d register settings; %0d fades finished, %0d commands refused.",
			beats_sent, settings_used, done_pulses, refusals);
		if (mismatches == 0 && outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
